// File: hdl/slc_pkg.sv
// Shared types and constants for the slope limiter cell core.
`default_nettype none
package slc_pkg;

	// Fixed register and field widths
	localparam int CFG_W    = 31;
	localparam int UNIT_W   = 17;
	localparam int OFFS_W   = 16;
	localparam int IDX_W    = 3;
	localparam int N_FIELDS = 10;
	localparam int OUT_W    = 24;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_HALF_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_HALF_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_HALF_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_UNIT   = 3'd3;
	localparam logic [IDX_W-1:0] REG_OFFSET = 3'd4;

	// Outcome of the ratio classification, travels beside the divider
	typedef struct packed {
		logic sat;   // zero denominator or quotient overflow
		logic zero;  // opposite signs or zero numerator
	} ratio_ctl_t;

endpackage
`default_nettype wire

// File: hdl/slope_limiter_cell_core.sv
// Top level of the slope limiter cell core: config, pipeline and output register.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_tvalid/s_tready  | s_tdata: ten signed values
//  m_      | out       | m_tvalid/m_tready  | m_tdata: limiter, m_tuser: saturated
//  cfg_    | in        | cfg_we             | cfg_index, cfg_data
//
// One item per cycle unless m_tready stalls; the pipeline has 4 front stages,
// (VALUE_BITS-1) divider stages of the bit-per-stage divider and 1 output
// stage. Reset clears all valid bits and loads register defaults. A stall on
// m_tready freezes the whole pipeline; nothing is lost.
`default_nettype none
module slope_limiter_cell_core import slc_pkg::*; #(
	parameter int VALUE_BITS    = 32,
	parameter int FRACTION_BITS = 16
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     s_tvalid,
	output logic                                          s_tready,
	// center, west, east, south, north, below, above, grad_x, grad_y, grad_z
	input  wire logic [((N_FIELDS*VALUE_BITS+7)/8)*8-1:0] s_tdata,
	output logic                                          m_tvalid,
	input  wire logic                                     m_tready,
	// limiter [16:0], zero fill
	output logic [OUT_W-1:0]                              m_tdata,
	// saturated
	output logic                                          m_tuser,
	input  wire logic                                     cfg_we,
	input  wire logic [IDX_W-1:0]                         cfg_index,
	input  wire logic [CFG_W-1:0]                         cfg_data
);

	localparam int VB  = VALUE_BITS;
	localparam int FB  = FRACTION_BITS;
	localparam int IB  = (VB - 1 - FB) > 0 ? (VB - 1 - FB) : 0;
	localparam int QB  = IB + FB;
	localparam int NA  = VB + CFG_W + 3 - FB;
	localparam int NB  = (VB + 3) > 20 ? (VB + 3) : 20;
	localparam int NW  = NA > NB ? NA : NB;
	localparam int RW  = QB > UNIT_W ? QB : UNIT_W;

	logic [CFG_W-1:0]  half_x_q, half_y_q, half_z_q;
	logic [UNIT_W-1:0] unit_q;
	logic [OFFS_W-1:0] offset_q;

	logic              en;
	logic              fv;
	logic [NW-1:0]     anx, adx, ann, adn;
	ratio_ctl_t        cx, cn, dcx, dcn;
	logic              dvx, dvn;
	logic [QB-1:0]     qx, qn;
	logic [RW-1:0]     rx, rn, lim;
	logic              m_tvalid_q;
	logic [UNIT_W-1:0] limiter_q;
	logic              sat_q;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_x_q <= CFG_W'(32768);
			half_y_q <= CFG_W'(32768);
			half_z_q <= CFG_W'(32768);
			unit_q   <= UNIT_W'(65536);
			offset_q <= OFFS_W'(1);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_HALF_X: half_x_q <= cfg_data;
				REG_HALF_Y: half_y_q <= cfg_data;
				REG_HALF_Z: half_z_q <= cfg_data;
				REG_UNIT:   unit_q   <= cfg_data[UNIT_W-1:0];
				REG_OFFSET: offset_q <= cfg_data[OFFS_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance everything when the output register is free
	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;

	slc_front #(
		.VALUE_BITS    (VB),
		.FRACTION_BITS (FB),
		.NW            (NW),
		.IB            (IB)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_tvalid),
		.in_data   (s_tdata[N_FIELDS*VB-1:0]),
		.half_x    (half_x_q),
		.half_y    (half_y_q),
		.half_z    (half_z_q),
		.offset    (offset_q),
		.out_valid (fv),
		.an_max    (anx),
		.ad_max    (adx),
		.ctl_max   (cx),
		.an_min    (ann),
		.ad_min    (adn),
		.ctl_min   (cn)
	);

	slc_div #(.NW(NW), .QB(QB), .FB(FB)) u_div_max (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fv),
		.an        (anx),
		.ad        (adx),
		.in_ctl    (cx),
		.out_valid (dvx),
		.quo       (qx),
		.out_ctl   (dcx)
	);

	slc_div #(.NW(NW), .QB(QB), .FB(FB)) u_div_min (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fv),
		.an        (ann),
		.ad        (adn),
		.in_ctl    (cn),
		.out_valid (dvn),
		.quo       (qn),
		.out_ctl   (dcn)
	);

	// Resolve each ratio and clamp to the unit limit
	always_comb begin
		rx = dcx.sat ? RW'(unit_q) : (dcx.zero ? '0 : RW'(qx));
		rn = dcn.sat ? RW'(unit_q) : (dcn.zero ? '0 : RW'(qn));
		lim = RW'(unit_q);
		if (rx < lim) lim = rx;
		if (rn < lim) lim = rn;
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			m_tvalid_q <= dvx;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			limiter_q <= lim[UNIT_W-1:0];
			sat_q     <= dcx.sat || dcn.sat;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'(limiter_q);
	assign m_tuser  = sat_q;

	// Both dividers move in lockstep
	a_div_lockstep: assert property (@(posedge clk) disable iff (!arst_n) dvx == dvn)
		else $error("divider valid bits diverged");

	// A ratio is never both saturated and forced to zero
	a_ctl_max: assert property (@(posedge clk) disable iff (!arst_n)
		dvx |-> !(dcx.sat && dcx.zero))
		else $error("max ratio classified twice");

	a_ctl_min: assert property (@(posedge clk) disable iff (!arst_n)
		dvn |-> !(dcn.sat && dcn.zero))
		else $error("min ratio classified twice");

endmodule
`default_nettype wire

// File: hdl/slc_front.sv
// Front stages: neighbor extremes, corner spread, numerators, denominators, classification.
`default_nettype none
module slc_front import slc_pkg::*; #(
	parameter int VALUE_BITS    = 32,
	parameter int FRACTION_BITS = 16,
	parameter int NW            = 50,
	parameter int IB            = 15
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic [N_FIELDS*VALUE_BITS-1:0] in_data,
	input  wire logic [CFG_W-1:0]               half_x,
	input  wire logic [CFG_W-1:0]               half_y,
	input  wire logic [CFG_W-1:0]               half_z,
	input  wire logic [OFFS_W-1:0]              offset,
	output logic                                out_valid,
	output logic [NW-1:0]                       an_max,
	output logic [NW-1:0]                       ad_max,
	output ratio_ctl_t                          ctl_max,
	output logic [NW-1:0]                       an_min,
	output logic [NW-1:0]                       ad_min,
	output ratio_ctl_t                          ctl_min
);

	localparam int VB = VALUE_BITS;
	localparam int PW = VB + CFG_W + 1;

	logic signed [VB-1:0] v [N_FIELDS];
	logic signed [VB-1:0] nmax_c, nmin_c;
	logic signed [PW-1:0] px_c, py_c, pz_c;

	logic                 valid_s1, valid_s2, valid_s3, valid_s4;
	logic signed [VB-1:0] q_s1, nmax_s1, nmin_s1;
	logic signed [PW-1:0] px_s1, py_s1, pz_s1;

	logic signed [PW-1:0] tx_c, ty_c, tz_c;
	logic signed [PW-1:0] ax_c, ay_c, az_c;
	logic signed [NW-1:0] sn_c, nmx_c, nmn_c;
	logic        [NW-1:0] spread_c;
	logic        [NW-1:0] spread_s2;
	logic signed [NW-1:0] nmx_s2, nmn_s2;

	logic signed [NW-1:0] nmx_s3, nmn_s3, dmx_s3, dmn_s3;

	logic        [NW-1:0] anx_c, adx_c, ann_c, adn_c;
	ratio_ctl_t           cx_c, cn_c;

	// Unpack fields
	always_comb begin
		for (int k = 0; k < N_FIELDS; k++) begin
			v[k] = in_data[k*VB +: VB];
		end
	end

	// Neighbor extremes over the six faces
	always_comb begin
		nmax_c = v[1];
		nmin_c = v[1];
		for (int k = 2; k < 7; k++) begin
			if (v[k] > nmax_c) nmax_c = v[k];
			if (v[k] < nmin_c) nmin_c = v[k];
		end
	end

	// Gradient times half size, exact
	assign px_c = PW'(v[7]) * $signed({1'b0, half_x});
	assign py_c = PW'(v[8]) * $signed({1'b0, half_y});
	assign pz_c = PW'(v[9]) * $signed({1'b0, half_z});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_s1    <= v[0];
			nmax_s1 <= nmax_c;
			nmin_s1 <= nmin_c;
			px_s1   <= px_c;
			py_s1   <= py_c;
			pz_s1   <= pz_c;
		end
	end

	// Floor shift, spread of the corners, numerators
	assign tx_c     = px_s1 >>> FRACTION_BITS;
	assign ty_c     = py_s1 >>> FRACTION_BITS;
	assign tz_c     = pz_s1 >>> FRACTION_BITS;
	assign ax_c     = tx_c[PW-1] ? -tx_c : tx_c;
	assign ay_c     = ty_c[PW-1] ? -ty_c : ty_c;
	assign az_c     = tz_c[PW-1] ? -tz_c : tz_c;
	assign spread_c = NW'(ax_c[PW-2:0]) + NW'(ay_c[PW-2:0]) + NW'(az_c[PW-2:0]);
	assign sn_c     = $signed(NW'(offset));
	assign nmx_c    = NW'(nmax_s1) - NW'(q_s1) + sn_c;
	assign nmn_c    = NW'(nmin_s1) - NW'(q_s1) + sn_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			spread_s2 <= spread_c;
			nmx_s2    <= nmx_c;
			nmn_s2    <= nmn_c;
		end
	end

	// Denominators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nmx_s3 <= nmx_s2;
			nmn_s3 <= nmn_s2;
			dmx_s3 <= $signed(spread_s2) + sn_c;
			dmn_s3 <= sn_c - $signed(spread_s2);
		end
	end

	// Classify each ratio and take magnitudes
	always_comb begin
		anx_c = nmx_s3[NW-1] ? NW'(-nmx_s3) : NW'(nmx_s3);
		adx_c = dmx_s3[NW-1] ? NW'(-dmx_s3) : NW'(dmx_s3);
		ann_c = nmn_s3[NW-1] ? NW'(-nmn_s3) : NW'(nmn_s3);
		adn_c = dmn_s3[NW-1] ? NW'(-dmn_s3) : NW'(dmn_s3);
		cx_c.zero = (dmx_s3 != '0) && ((nmx_s3 == '0) || (nmx_s3[NW-1] != dmx_s3[NW-1]));
		cx_c.sat  = (dmx_s3 == '0) || (!cx_c.zero && ((anx_c >> IB) >= adx_c));
		cn_c.zero = (dmn_s3 != '0) && ((nmn_s3 == '0) || (nmn_s3[NW-1] != dmn_s3[NW-1]));
		cn_c.sat  = (dmn_s3 == '0) || (!cn_c.zero && ((ann_c >> IB) >= adn_c));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			an_max  <= anx_c;
			ad_max  <= adx_c;
			ctl_max <= cx_c;
			an_min  <= ann_c;
			ad_min  <= adn_c;
			ctl_min <= cn_c;
		end
	end

	assign out_valid = valid_s4;

endmodule
`default_nettype wire

// File: hdl/slc_div.sv
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module slc_div import slc_pkg::*; #(
	parameter int NW = 50,
	parameter int QB = 31,
	parameter int FB = 16
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          in_valid,
	input  wire logic [NW-1:0] an,
	input  wire logic [NW-1:0] ad,
	input  wire ratio_ctl_t    in_ctl,
	output logic               out_valid,
	output logic [QB-1:0]      quo,
	output ratio_ctl_t         out_ctl
);

	localparam int IB = QB - FB;

	// Index 0 is the input, index i the register after stage i
	logic              valid_s [QB+1];
	logic [NW:0]       rem_s   [QB+1];
	logic [QB-1:0]     quo_s   [QB+1];
	logic [NW-1:0]     an_s    [QB+1];
	logic [NW-1:0]     ad_s    [QB+1];
	ratio_ctl_t        ctl_s   [QB+1];

	assign valid_s[0] = in_valid;
	assign rem_s[0]   = (NW+1)'(an >> IB);
	assign quo_s[0]   = '0;
	assign an_s[0]    = an;
	assign ad_s[0]    = ad;
	assign ctl_s[0]   = in_ctl;

	for (genvar i = 0; i < QB; i++) begin : g_stage
		localparam int B = QB - 1 - i;
		logic          nbit;
		logic [NW:0]   trial;
		logic          take;

		if (B >= FB) begin : g_bit
			assign nbit = an_s[i][B-FB];
		end else begin : g_zero
			assign nbit = 1'b0;
		end

		// Shift in the next dividend bit, subtract when it fits
		assign trial = {rem_s[i][NW-1:0], nbit};
		assign take  = trial >= {1'b0, ad_s[i]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[i+1] <= 1'b0;
			end else if (en) begin
				valid_s[i+1] <= valid_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= take ? trial - {1'b0, ad_s[i]} : trial;
				quo_s[i+1] <= {quo_s[i][QB-2:0], take};
				an_s[i+1]  <= an_s[i];
				ad_s[i+1]  <= ad_s[i];
				ctl_s[i+1] <= ctl_s[i];
			end
		end
	end

	assign out_valid = valid_s[QB];
	assign quo       = quo_s[QB];
	assign out_ctl   = ctl_s[QB];

endmodule
`default_nettype wire
